@@ src/bdqs_pkg.sv @@
// Shared types and constants for the bounded deque with search unit.
`timescale 1ns / 1ps
`default_nettype none

package bdqs_pkg;

  // Operation codes carried by the kind field.
  typedef enum logic [3:0] {
    KIND_PUSH   = 4'd0,
    KIND_POP    = 4'd1,
    KIND_REMOVE = 4'd2,
    KIND_PEEK   = 4'd3,
    KIND_FIND   = 4'd4,
    KIND_ROTATE = 4'd5,
    KIND_HASH   = 4'd6,
    KIND_SIZE   = 4'd7,
    KIND_CLEAR  = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

  // What every cell does with its entry when an operation is applied.
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_SHIFT_LEFT = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_ROTATE     = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CALC  = 2'd1,
    ST_APPLY = 2'd2
  } state_e;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    act_e        act;
    logic        calc_en;
    logic        apply_en;
    logic        from_back;
    logic [31:0] operand;
    logic [31:0] front;
  } cell_ctrl_t;

  localparam int unsigned HashStep      = 7;
  localparam int unsigned HashFillShift = 16;

endpackage

`default_nettype wire

@@ src/bdqs_cell.sv @@
// One deque cell: holds one entry, its compare result and its hash term.
`timescale 1ns / 1ps
`default_nettype none

module bdqs_cell #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned Idx      = 0,
  localparam int unsigned FillW   = $clog2(Capacity + 1)
) (
  input  wire logic                   clk_i,
  input  wire bdqs_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic [FillW-1:0]       fill_i,
  input  wire logic [31:0]            left_i,
  input  wire logic [31:0]            right_i,
  input  wire logic                   seen_i,
  output logic                        seen_o,
  output logic [31:0]                 value_o,
  output logic [31:0]                 term_o,
  output logic [31:0]                 tail_o
);

  logic [31:0]      value_q, value_d;
  logic [31:0]      term_q, term_d;
  logic             match_q, match_d;
  logic             held;
  logic             is_last;
  logic             is_next;
  logic [FillW-1:0] pos;

  assign held    = fill_i > FillW'(Idx);
  assign is_last = fill_i == FillW'(Idx + 1);
  assign is_next = fill_i == FillW'(Idx);

  // Position counted from the chosen end of the queue.
  assign pos = ctrl_i.from_back ? (fill_i - FillW'(Idx + 1)) : FillW'(Idx);

  always_comb begin
    match_d = match_q;
    term_d  = term_q;
    if (ctrl_i.calc_en) begin
      match_d = held && (value_q == ctrl_i.operand);
      term_d  = held ? (value_q + 32'(pos) * 32'(bdqs_pkg::HashStep)) : 32'd0;
    end
  end

  // A match here or further towards the front shifts this entry left on removal.
  assign seen_o = seen_i | match_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.apply_en) begin
      case (ctrl_i.act)
        bdqs_pkg::ACT_PUSH_FRONT: value_d = (Idx == 0) ? ctrl_i.operand : left_i;
        bdqs_pkg::ACT_PUSH_BACK:  value_d = is_next ? ctrl_i.operand : value_q;
        bdqs_pkg::ACT_SHIFT_LEFT: value_d = right_i;
        bdqs_pkg::ACT_REMOVE:     value_d = seen_o ? right_i : value_q;
        bdqs_pkg::ACT_ROTATE:     value_d = is_last ? ctrl_i.front : right_i;
        default:                  value_d = value_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    term_q  <= term_d;
    match_q <= match_d;
  end

  assign value_o = value_q;
  assign term_o  = term_q;
  assign tail_o  = is_last ? value_q : 32'd0;

endmodule

`default_nettype wire

@@ src/bounded_deque_with_search_unit.sv @@
// A compare and hash-term stage runs in every cell, then an apply stage updates the
// cell row and loads the output register; the apply stage waits while a stalled
// result still holds the output register.
// The next input transfer is taken in the apply cycle when the output register is free.
// Reset clears the sequencer, the entry count, the reported value and the output valid;
// the cell entries themselves are not reset.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_search_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  kind_i,
  input  wire logic        at_tail_i,
  input  wire logic [31:0] operand_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      reported_o,
  output logic [4:0]       occupancy_o
);

  localparam int unsigned FillW = $clog2(CAPACITY + 1);

  bdqs_pkg::state_e     state_q, state_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic [31:0]          report_q, report_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           status_q, status_d;
  logic [4:0]           occ_q;
  logic [3:0]           kind_q;
  logic                 tail_q;
  logic [31:0]          operand_q;

  bdqs_pkg::cell_ctrl_t ctrl;
  bdqs_pkg::act_e       act;
  bdqs_pkg::status_e    status_n;
  logic [FillW-1:0]     fill_n;
  logic [31:0]          report_n;

  logic [31:0]          cell_val  [CAPACITY];
  logic [31:0]          cell_term [CAPACITY];
  logic [31:0]          cell_tail [CAPACITY];
  logic [CAPACITY:0]    seen;

  logic                 in_fire;
  logic                 out_free;
  logic                 apply_fire;
  logic                 calc_en;
  logic                 empty;
  logic                 full;
  logic                 found;
  logic [31:0]          hash_xor;
  logic [31:0]          tail_val;
  logic [31:0]          hash_val;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign calc_en    = state_q == bdqs_pkg::ST_CALC;
  assign apply_fire = (state_q == bdqs_pkg::ST_APPLY) && out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdqs_pkg::ST_IDLE:  if (in_fire) state_d = bdqs_pkg::ST_CALC;
      bdqs_pkg::ST_CALC:  state_d = bdqs_pkg::ST_APPLY;
      bdqs_pkg::ST_APPLY: begin
        if (apply_fire) state_d = in_fire ? bdqs_pkg::ST_CALC : bdqs_pkg::ST_IDLE;
      end
      default:            state_d = bdqs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    unique case (state_q)
      bdqs_pkg::ST_IDLE:  in_stall_o = 1'b0;
      bdqs_pkg::ST_CALC:  in_stall_o = 1'b1;
      bdqs_pkg::ST_APPLY: in_stall_o = !out_free;
      default:            in_stall_o = 1'b1;
    endcase
  end

  // Reductions over the cell row.
  always_comb begin
    hash_xor = 32'd0;
    tail_val = 32'd0;
    for (int i = 0; i < CAPACITY; i++) begin
      hash_xor = hash_xor ^ cell_term[i];
      tail_val = tail_val | cell_tail[i];
    end
  end

  assign empty    = fill_q == '0;
  assign full     = fill_q == FillW'(CAPACITY);
  assign found    = seen[CAPACITY];
  assign hash_val = hash_xor ^ ((32'(fill_q) << bdqs_pkg::HashFillShift) | 32'(fill_q));

  // Operation decoder.
  always_comb begin
    act      = bdqs_pkg::ACT_NONE;
    status_n = bdqs_pkg::STATUS_OK;
    fill_n   = fill_q;
    report_n = report_q;
    unique case (kind_q)
      bdqs_pkg::KIND_PUSH: begin
        if (full) status_n = bdqs_pkg::STATUS_FULL;
        else begin
          act    = tail_q ? bdqs_pkg::ACT_PUSH_BACK : bdqs_pkg::ACT_PUSH_FRONT;
          fill_n = fill_q + 1'b1;
        end
      end
      bdqs_pkg::KIND_POP: begin
        if (empty) status_n = bdqs_pkg::STATUS_EMPTY;
        else begin
          act    = tail_q ? bdqs_pkg::ACT_NONE : bdqs_pkg::ACT_SHIFT_LEFT;
          fill_n = fill_q - 1'b1;
        end
      end
      bdqs_pkg::KIND_REMOVE: begin
        if (!found) status_n = bdqs_pkg::STATUS_MISSING;
        else begin
          act    = bdqs_pkg::ACT_REMOVE;
          fill_n = fill_q - 1'b1;
        end
      end
      bdqs_pkg::KIND_PEEK: begin
        if (empty) status_n = bdqs_pkg::STATUS_EMPTY;
        else report_n = tail_q ? tail_val : cell_val[0];
      end
      bdqs_pkg::KIND_FIND: begin
        // A hit holds exactly the value searched for.
        if (!found) status_n = bdqs_pkg::STATUS_MISSING;
        else report_n = operand_q;
      end
      bdqs_pkg::KIND_ROTATE: begin
        if (empty) status_n = bdqs_pkg::STATUS_EMPTY;
        else act = bdqs_pkg::ACT_ROTATE;
      end
      bdqs_pkg::KIND_HASH: begin
        if (empty) status_n = bdqs_pkg::STATUS_EMPTY;
        else report_n = hash_val;
      end
      bdqs_pkg::KIND_SIZE: report_n = 32'(fill_q);
      bdqs_pkg::KIND_CLEAR: begin
        if (empty) status_n = bdqs_pkg::STATUS_EMPTY;
        else fill_n = '0;
      end
      default: ;
    endcase
  end

  assign ctrl.act       = act;
  assign ctrl.calc_en   = calc_en;
  assign ctrl.apply_en  = apply_fire;
  assign ctrl.from_back = tail_q;
  assign ctrl.operand   = operand_q;
  assign ctrl.front     = cell_val[0];

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] left_v;
    logic [31:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = operand_q;
    end else begin : g_mid
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_inner
      assign right_v = cell_val[g+1];
    end
    bdqs_cell #(
      .Capacity(CAPACITY),
      .Idx     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .fill_i (fill_q),
      .left_i (left_v),
      .right_i(right_v),
      .seen_i (seen[g]),
      .seen_o (seen[g+1]),
      .value_o(cell_val[g]),
      .term_o (cell_term[g]),
      .tail_o (cell_tail[g])
    );
  end

  assign fill_d      = apply_fire ? fill_n : fill_q;
  assign report_d    = apply_fire ? report_n : report_q;
  assign status_d    = apply_fire ? status_n : status_q;
  assign out_valid_d = apply_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdqs_pkg::ST_IDLE;
      fill_q      <= '0;
      report_q    <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      report_q    <= report_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q    <= kind_i;
      tail_q    <= at_tail_i;
      operand_q <= operand_i;
    end
    status_q <= status_d;
    if (apply_fire) occ_q <= 5'(fill_n);
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign reported_o  = report_q;
  assign occupancy_o = occ_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(CAPACITY))
    else $error("entry count above capacity");

  a_result_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bdqs_pkg::ST_APPLY))
    else $error("result offered without an apply cycle");

  a_accept_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (state_q == bdqs_pkg::ST_IDLE || state_q == bdqs_pkg::ST_APPLY))
    else $error("input transfer taken while busy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == bdqs_pkg::STATUS_FULL) |-> full)
    else $error("full status reported below capacity");

  a_fill_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdqs_pkg::ST_CALC) |=> $stable(fill_q))
    else $error("entry count changed outside an apply cycle");

endmodule

`default_nettype wire

@@ tb/sv/tb_bounded_deque_with_search_unit.sv @@
// Self-checking testbench for the bounded deque with search unit.
`timescale 1ns / 1ps

module tb_bounded_deque_with_search_unit;

  localparam int unsigned DEPTH = 16;
  localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

  typedef struct packed {
    bdqs_pkg::status_e status;
    logic [31:0]       reported;
    logic [4:0]        occupancy;
  } deque_result_t;

  typedef struct packed {
    logic [3:0]    kind;
    logic          tail;
    logic [31:0]   operand;
    logic          typed;
    deque_result_t result;
  } op_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [3:0]  kind_i      = 4'd0;
  logic        at_tail_i   = 1'b0;
  logic [31:0] operand_i   = 32'd0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [31:0] reported_o;
  logic [4:0]  occupancy_o;

  // Mirror of the deque contents and the reported-value register.
  logic [31:0] dq_slots [DEPTH];
  int unsigned dq_fill   = 0;
  logic [31:0] dq_report = 32'd0;

  deque_result_t awaited_results [$];
  op_row_t       directed_ops [$];
  int unsigned   mismatch_count = 0;
  int unsigned   burst_left     = 0;
  int unsigned   stall_tick     = 0;
  int unsigned   stall_mode     = 0;

  bounded_deque_with_search_unit #(
    .CAPACITY(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .at_tail_i  (at_tail_i),
    .operand_i  (operand_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .reported_o (reported_o),
    .occupancy_o(occupancy_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Removes the entry at pos and closes the gap behind it.
  function automatic void drop_entry(input int unsigned pos);
    int unsigned k;
    for (k = pos; k + 1 < dq_fill; k++) begin
      dq_slots[k] = dq_slots[k + 1];
    end
    dq_fill--;
  endfunction

  // First position holding the value, or the fill level when none does.
  function automatic int unsigned locate_value(input logic [31:0] value);
    int unsigned k;
    for (k = 0; k < dq_fill; k++) begin
      if (dq_slots[k] == value) return k;
    end
    return dq_fill;
  endfunction

  function automatic deque_result_t predict_deque_op(input logic [3:0] kind, input logic tail,
                                                     input logic [31:0] opnd);
    deque_result_t res;
    int unsigned   pos;
    int unsigned   k;
    logic [31:0]   head;
    logic [31:0]   digest;
    logic [31:0]   entry;
    res.status = bdqs_pkg::STATUS_OK;
    case (kind)
      bdqs_pkg::KIND_PUSH: begin
        if (dq_fill >= DEPTH) begin
          res.status = bdqs_pkg::STATUS_FULL;
        end else if (tail) begin
          dq_slots[dq_fill] = opnd;
          dq_fill++;
        end else begin
          for (k = dq_fill; k > 0; k--) dq_slots[k] = dq_slots[k - 1];
          dq_slots[0] = opnd;
          dq_fill++;
        end
      end
      bdqs_pkg::KIND_POP: begin
        if (dq_fill == 0) res.status = bdqs_pkg::STATUS_EMPTY;
        else if (tail) dq_fill--;
        else drop_entry(0);
      end
      bdqs_pkg::KIND_REMOVE: begin
        pos = locate_value(opnd);
        if (pos >= dq_fill) res.status = bdqs_pkg::STATUS_MISSING;
        else drop_entry(pos);
      end
      bdqs_pkg::KIND_PEEK: begin
        if (dq_fill == 0) res.status = bdqs_pkg::STATUS_EMPTY;
        else dq_report = tail ? dq_slots[dq_fill - 1] : dq_slots[0];
      end
      bdqs_pkg::KIND_FIND: begin
        pos = locate_value(opnd);
        if (pos >= dq_fill) res.status = bdqs_pkg::STATUS_MISSING;
        else dq_report = dq_slots[pos];
      end
      bdqs_pkg::KIND_ROTATE: begin
        if (dq_fill == 0) begin
          res.status = bdqs_pkg::STATUS_EMPTY;
        end else begin
          head = dq_slots[0];
          drop_entry(0);
          dq_slots[dq_fill] = head;
          dq_fill++;
        end
      end
      bdqs_pkg::KIND_HASH: begin
        if (dq_fill == 0) begin
          res.status = bdqs_pkg::STATUS_EMPTY;
        end else begin
          digest = 32'd0;
          for (k = 0; k < dq_fill; k++) begin
            entry  = tail ? dq_slots[dq_fill - 1 - k] : dq_slots[k];
            digest = digest ^ (entry + 32'(bdqs_pkg::HashStep * k));
          end
          dq_report = digest ^ ((32'(dq_fill) << bdqs_pkg::HashFillShift) | 32'(dq_fill));
        end
      end
      bdqs_pkg::KIND_SIZE: dq_report = 32'(dq_fill);
      bdqs_pkg::KIND_CLEAR: begin
        if (dq_fill == 0) res.status = bdqs_pkg::STATUS_EMPTY;
        else dq_fill = 0;
      end
      default: ;
    endcase
    res.reported  = dq_report;
    res.occupancy = 5'(dq_fill);
    return res;
  endfunction

  // Holds one operation on the input until its transfer, then records what it should yield.
  task automatic send_op(input logic [3:0] kind, input logic tail, input logic [31:0] opnd,
                         input logic typed, input deque_result_t typed_res);
    deque_result_t res;
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    in_valid_i = 1'b1;
    kind_i     = kind;
    at_tail_i  = tail;
    operand_i  = opnd;
    do @(posedge clk_i); while (in_stall_o);
    res = predict_deque_op(kind, tail, opnd);
    awaited_results.push_back(typed ? typed_res : res);
    burst_left--;
    @(negedge clk_i);
  endtask

  function automatic void add_op(input logic [3:0] kind, input logic tail,
                                 input logic [31:0] opnd, input logic typed,
                                 input bdqs_pkg::status_e st, input logic [31:0] rep,
                                 input logic [4:0] occ);
    op_row_t r;
    r.kind               = kind;
    r.tail               = tail;
    r.operand            = opnd;
    r.typed              = typed;
    r.result.status      = st;
    r.result.reported    = rep;
    r.result.occupancy   = occ;
    directed_ops.push_back(r);
  endfunction

  // Push values come partly from a small pool so that duplicates and repeated matches occur.
  function automatic logic [31:0] pick_push_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 7));
      4:          return 32'hFFFF_FFFF;
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_search_value();
    if (dq_fill > 0 && $urandom_range(0, 3) != 0) return dq_slots[$urandom_range(0, dq_fill - 1)];
    return ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
  endfunction

  // Cumulative weights per traffic mix: filling, draining and balanced.
  int unsigned mix_cut [3][10] = '{
    '{60, 68, 74, 80, 86, 90, 94, 96, 97, 100},
    '{15, 50, 65, 71, 77, 83, 89, 93, 97, 100},
    '{33, 53, 63, 70, 78, 84, 90, 94, 96, 100}
  };

  initial begin
    op_row_t       r;
    deque_result_t none;
    int unsigned   n;
    int unsigned   mix;
    int unsigned   mix_left;
    int unsigned   roll;
    int unsigned   j;
    logic [3:0]    kind;
    logic [31:0]   opnd;
    none = '0;

    add_op(bdqs_pkg::KIND_SIZE,   1'b0, 32'h0, 1'b1, bdqs_pkg::STATUS_OK, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_POP,    1'b1, 32'h0, 1'b1, bdqs_pkg::STATUS_EMPTY, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_PEEK,   1'b1, 32'h0, 1'b1, bdqs_pkg::STATUS_EMPTY, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_ROTATE, 1'b0, 32'h0, 1'b1, bdqs_pkg::STATUS_EMPTY, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_HASH,   1'b0, 32'h0, 1'b1, bdqs_pkg::STATUS_EMPTY, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_CLEAR,  1'b0, 32'h0, 1'b1, bdqs_pkg::STATUS_EMPTY, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_REMOVE, 1'b0, 32'h0, 1'b1, bdqs_pkg::STATUS_MISSING, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_FIND,   1'b1, 32'hFFFF_FFFF, 1'b1, bdqs_pkg::STATUS_MISSING,
           32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_PUSH,   1'b1, 32'hFFFF_FFFF, 1'b1, bdqs_pkg::STATUS_OK,
           32'h0, 5'd1);
    add_op(bdqs_pkg::KIND_PUSH,   1'b0, 32'h0, 1'b1, bdqs_pkg::STATUS_OK, 32'h0, 5'd2);
    add_op(bdqs_pkg::KIND_PEEK,   1'b0, 32'h0, 1'b1, bdqs_pkg::STATUS_OK, 32'h0, 5'd2);
    add_op(bdqs_pkg::KIND_PEEK,   1'b1, 32'h0, 1'b1, bdqs_pkg::STATUS_OK,
           32'hFFFF_FFFF, 5'd2);
    add_op(bdqs_pkg::KIND_HASH,   1'b0, 32'h0, 1'b0, bdqs_pkg::STATUS_OK, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_HASH,   1'b1, 32'h0, 1'b0, bdqs_pkg::STATUS_OK, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_FIND,   1'b0, 32'h0, 1'b1, bdqs_pkg::STATUS_OK, 32'h0, 5'd2);
    add_op(bdqs_pkg::KIND_PUSH,   1'b0, 32'h8000_0000, 1'b1, bdqs_pkg::STATUS_OK,
           32'h0, 5'd3);
    add_op(bdqs_pkg::KIND_ROTATE, 1'b1, 32'h0, 1'b0, bdqs_pkg::STATUS_OK, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_REMOVE, 1'b1, 32'hFFFF_FFFF, 1'b0, bdqs_pkg::STATUS_OK,
           32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_REMOVE, 1'b0, 32'h1234_5678, 1'b1, bdqs_pkg::STATUS_MISSING,
           32'h0, 5'd2);
    add_op(KIND_UNUSED_HI, 1'b1, 32'hFFFF_FFFF, 1'b0, bdqs_pkg::STATUS_OK, 32'h0, 5'd0);
    add_op(KIND_UNUSED_LO, 1'b0, 32'h0, 1'b0, bdqs_pkg::STATUS_OK, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_SIZE,   1'b1, 32'h0, 1'b1, bdqs_pkg::STATUS_OK, 32'h2, 5'd2);
    add_op(bdqs_pkg::KIND_POP,    1'b0, 32'h0, 1'b0, bdqs_pkg::STATUS_OK, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_CLEAR,  1'b1, 32'h0, 1'b0, bdqs_pkg::STATUS_OK, 32'h0, 5'd0);
    add_op(bdqs_pkg::KIND_SIZE,   1'b0, 32'h0, 1'b1, bdqs_pkg::STATUS_OK, 32'h0, 5'd0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_ops[i]) begin
      r = directed_ops[i];
      send_op(r.kind, r.tail, r.operand, r.typed, r.result);
    end

    mix      = 0;
    mix_left = 0;
    for (n = 0; n < 600; n++) begin
      if (mix_left == 0) begin
        mix      = $urandom_range(0, 2);
        mix_left = $urandom_range(30, 60);
      end
      mix_left--;
      roll = $urandom_range(0, 99);
      j    = 0;
      while (roll >= mix_cut[mix][j]) j++;
      if (j == 9) kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      else kind = 4'(j);
      case (kind)
        bdqs_pkg::KIND_PUSH:                        opnd = pick_push_value();
        bdqs_pkg::KIND_REMOVE, bdqs_pkg::KIND_FIND: opnd = pick_search_value();
        default:                                    opnd = $urandom;
      endcase
      send_op(kind, 1'($urandom_range(0, 1)), opnd, 1'b0, none);
    end
    in_valid_i = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // The receiver switches every so often between no stalls, light and heavy random stalls
  // and a fixed periodic pattern.
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 150 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 9) < 3);
      2:       out_stall_i <= ((stall_tick % 7) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d reported %h occupancy %0d",
               status_o, reported_o, occupancy_o);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (reported_o !== want.reported) begin
          $error("reported: expected %h, got %h", want.reported, reported_o);
          mismatch_count++;
        end
        if (occupancy_o !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
